/* rtl/fragment_coverage_binner_assert.svh */
// assertion macros used by the coverage binner top level
`ifndef FRAGMENT_COVERAGE_BINNER_ASSERT_SVH
`define FRAGMENT_COVERAGE_BINNER_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define FCB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define FCB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/fcb_pkg.sv */
// types and constants of the fragment coverage binner
package fcb_pkg;

  // item and result field widths
  localparam int unsigned EndW     = 30;
  localparam int unsigned WeightW  = 16;
  localparam int unsigned BinIdxW  = 18;
  localparam int unsigned ValueW   = 32;

  // configuration registers
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 30;
  localparam int unsigned BinSizeW = 20;
  localparam int unsigned LenW     = 16;
  localparam int unsigned ChromW   = 30;
  localparam int unsigned GainW    = 16;

  localparam logic [BinSizeW-1:0] BinSizeRst = 20'd100;
  localparam logic [LenW-1:0]     LenRst     = 16'd0;
  localparam logic [ChromW-1:0]   ChromRst   = 30'h3FFF_FFFF;
  localparam logic [GainW-1:0]    GainRst    = 16'd256;

  // datapath widths
  localparam int unsigned PosW     = 33;  // signed positions, window start may go negative
  localparam int unsigned QuotW    = 32;  // bin numbers and divider dividend
  localparam int unsigned CountW   = 32;  // stored bin count
  localparam int unsigned ProdW    = CountW + GainW;
  localparam int unsigned GainFrac = 8;

  localparam int unsigned LongFragment = 300;

  typedef logic signed [PosW-1:0] fcb_pos_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BIN_SIZE,
    REG_CENTER_LEN,
    REG_READ_REGION,
    REG_CHROM_LEN,
    REG_FWD_LEN,
    REG_REV_LEN,
    REG_GAIN
  } fcb_reg_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ORDER,
    ST_WINDOW,
    ST_CLAMP,
    ST_PLAN,
    ST_DIV_LO,
    ST_WAIT_LO,
    ST_DIV_HI,
    ST_WAIT_HI,
    ST_RANGE,
    ST_RMW_RD,
    ST_RMW_WR,
    ST_RD_ADDR,
    ST_RD_MUL,
    ST_RD_OUT
  } fcb_state_e;

  typedef struct packed {
    logic latch;
    logic order;
    logic window;
    logic clamp;
    logic plan;
    logic div_start;
    logic div_hi;
    logic lo_take;
    logic hi_take;
    logic span_next;
    logic range_load;
    logic rmw_wr;
    logic j_inc;
    logic mul;
    logic out_load;
    logic clr_wr;
  } fcb_cmd_t;

  typedef struct packed {
    logic in_kind;
    logic in_dup;
    logic clr_last;
    logic div_done;
    logic span_empty;
    logic span_last;
    logic more_spans;
  } fcb_stat_t;

endpackage

/* rtl/fcb_if.sv */
// valid/ready channel interfaces for fragment items and bin results
interface fcb_item_if import fcb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               kind;
  logic [EndW-1:0]    end_a;
  logic [EndW-1:0]    end_b;
  logic [WeightW-1:0] weight;
  logic               is_duplicate;
  logic [BinIdxW-1:0] bin_index;

  modport source (output valid, kind, end_a, end_b, weight, is_duplicate, bin_index,
                  input ready);
  modport sink   (input valid, kind, end_a, end_b, weight, is_duplicate, bin_index,
                  output ready);
endinterface

interface fcb_result_if import fcb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ValueW-1:0] bin_value;

  modport source (output valid, bin_value, input ready);
  modport sink   (input valid, bin_value, output ready);
endinterface

/* rtl/fcb_ram.sv */
// generic single-write, single-read ram with registered read data
module fcb_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/fcb_div.sv */
// bit-serial restoring divider: position magnitude by bin size
module fcb_div import fcb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [QuotW-1:0]    dividend_i,
  input  logic [BinSizeW-1:0] divisor_i,
  output logic                done_o,
  output logic [QuotW-1:0]    quot_o
);

  localparam int unsigned CntW = $clog2(QuotW + 1);

  logic [QuotW-1:0]    quo_q;
  logic [BinSizeW-1:0] rem_q;
  logic [CntW-1:0]     cnt_q;
  logic                busy_q;
  logic                done_q;
  logic [BinSizeW:0]   rem_sh;
  logic [BinSizeW:0]   diff;
  logic                ge;

  always_comb begin
    rem_sh = {rem_q, quo_q[QuotW-1]};
    diff   = rem_sh - {1'b0, divisor_i};
    ge     = !diff[BinSizeW];
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[BinSizeW-1:0] : rem_sh[BinSizeW-1:0];
      quo_q <= {quo_q[QuotW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && (cnt_q == CntW'(1));
      if (start_i) begin
        cnt_q  <= CntW'(QuotW);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

/* rtl/fcb_datapath.sv */
// datapath: config registers, fragment geometry, divider, bin update and readout
module fcb_datapath import fcb_pkg::*; #(
  parameter int unsigned NUM_BINS = 262144
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [CfgIdxW-1:0]          cfg_idx_i,
  input  logic [CfgDataW-1:0]         cfg_data_i,
  input  logic                        kind_i,
  input  logic [EndW-1:0]             end_a_i,
  input  logic [EndW-1:0]             end_b_i,
  input  logic [WeightW-1:0]          weight_i,
  input  logic                        is_duplicate_i,
  input  logic [BinIdxW-1:0]          bin_index_i,
  input  fcb_cmd_t                    cmd_i,
  output fcb_stat_t                   stat_o,
  output logic                        ram_we_o,
  output logic [$clog2(NUM_BINS)-1:0] ram_waddr_o,
  output logic [CountW-1:0]           ram_wdata_o,
  output logic [$clog2(NUM_BINS)-1:0] ram_raddr_o,
  input  logic [CountW-1:0]           ram_rdata_i,
  output logic [ValueW-1:0]           bin_value_o
);

  localparam int unsigned AddrW = $clog2(NUM_BINS);
  localparam logic [QuotW-1:0] MaxBin = QuotW'(NUM_BINS - 1);
  localparam logic [QuotW-1:0] NumBins = QuotW'(NUM_BINS);

  // configuration
  logic [BinSizeW-1:0] bin_size_q;
  logic [LenW-1:0]     center_len_q;
  logic                rro_q;
  logic [ChromW-1:0]   chrom_q;
  logic [LenW-1:0]     fwd_len_q;
  logic [LenW-1:0]     rev_len_q;
  logic [GainW-1:0]    gain_q;

  // latched transaction
  logic               kind_q;
  logic [EndW-1:0]    a_q;
  logic [EndW-1:0]    b_q;
  logic [WeightW-1:0] w_q;
  logic [BinIdxW-1:0] idx_q;
  logic               rd_ok_q;

  // fragment geometry
  fcb_pos_t s_q, e_q, t_q;
  fcb_pos_t p_lo0_q, p_hi0_q, p_lo1_q, p_hi1_q;
  logic     two_q;
  logic     span_sel_q;

  fcb_pos_t a_pos, b_pos, cl_pos, fwd_pos, rev_pos;
  fcb_pos_t ord_s, ord_e, t_d;
  fcb_pos_t t_rnd, half, win_s, win_e;
  fcb_pos_t lim, clp_s, clp_e;
  fcb_pos_t diff, hi0_d;
  logic     long_frag;
  fcb_pos_t cur_lo, cur_hi, div_op, div_abs;

  // bins
  logic [BinSizeW-1:0] d_eff;
  logic                div_done;
  logic [QuotW-1:0]    quot;
  logic [QuotW-1:0]    lo_bin_q, hi_bin_q;
  logic                hi_neg_q;
  logic [AddrW-1:0]    j_q;
  logic [AddrW-1:0]    clr_q;
  logic [QuotW-1:0]    idx_ext;
  logic [CountW:0]     sum;
  logic [CountW-1:0]   wsum;
  logic [ProdW-1:0]    prod_q;
  logic [ValueW-1:0]   value_q;
  logic [ValueW-1:0]   value_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_size_q   <= BinSizeRst;
      center_len_q <= LenRst;
      rro_q        <= 1'b0;
      chrom_q      <= ChromRst;
      fwd_len_q    <= LenRst;
      rev_len_q    <= LenRst;
      gain_q       <= GainRst;
    end else if (cfg_we_i) begin
      case (fcb_reg_e'(cfg_idx_i))
        REG_BIN_SIZE:    bin_size_q   <= cfg_data_i[BinSizeW-1:0];
        REG_CENTER_LEN:  center_len_q <= cfg_data_i[LenW-1:0];
        REG_READ_REGION: rro_q        <= cfg_data_i[0];
        REG_CHROM_LEN:   chrom_q      <= cfg_data_i[ChromW-1:0];
        REG_FWD_LEN:     fwd_len_q    <= cfg_data_i[LenW-1:0];
        REG_REV_LEN:     rev_len_q    <= cfg_data_i[LenW-1:0];
        REG_GAIN:        gain_q       <= cfg_data_i[GainW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      kind_q  <= kind_i;
      a_q     <= end_a_i;
      b_q     <= end_b_i;
      w_q     <= weight_i;
      idx_q   <= bin_index_i;
      rd_ok_q <= {{(QuotW-BinIdxW){1'b0}}, bin_index_i} < NumBins;
    end
  end

  always_comb begin
    a_pos   = fcb_pos_t'({{(PosW-EndW){1'b0}}, a_q});
    b_pos   = fcb_pos_t'({{(PosW-EndW){1'b0}}, b_q});
    cl_pos  = fcb_pos_t'({{(PosW-LenW){1'b0}}, center_len_q});
    fwd_pos = fcb_pos_t'({{(PosW-LenW){1'b0}}, fwd_len_q});
    rev_pos = fcb_pos_t'({{(PosW-LenW){1'b0}}, rev_len_q});

    ord_s = (a_pos < b_pos) ? a_pos : b_pos;
    ord_e = (a_pos < b_pos) ? b_pos : a_pos;
    // sum of the ends does not depend on their order
    t_d   = a_pos + b_pos - cl_pos;

    // halve toward zero
    t_rnd = t_q + fcb_pos_t'({{(PosW-1){1'b0}}, t_q[PosW-1]});
    half  = {t_rnd[PosW-1], t_rnd[PosW-1:1]};
    win_s = (center_len_q != '0) ? half : s_q;
    win_e = (center_len_q != '0) ? half + cl_pos : e_q;

    lim   = fcb_pos_t'({{(PosW-ChromW){1'b0}}, chrom_q}) - fcb_pos_t'(1);
    clp_s = s_q[PosW-1] ? '0 : s_q;
    clp_e = (e_q > lim) ? lim : e_q;

    diff      = e_q - s_q;
    long_frag = rro_q && (diff > fcb_pos_t'(LongFragment));
    hi0_d     = long_frag ? s_q + fwd_pos : e_q;

    cur_lo  = span_sel_q ? p_lo1_q : p_lo0_q;
    cur_hi  = span_sel_q ? p_hi1_q : p_hi0_q;
    div_op  = cmd_i.div_hi ? cur_hi : cur_lo;
    div_abs = div_op[PosW-1] ? -div_op : div_op;
    d_eff   = (bin_size_q == '0) ? BinSizeW'(1) : bin_size_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.order) begin
      s_q <= ord_s;
      e_q <= ord_e;
      t_q <= t_d;
    end else if (cmd_i.window) begin
      s_q <= win_s;
      e_q <= win_e;
    end else if (cmd_i.clamp) begin
      s_q <= clp_s;
      e_q <= clp_e;
    end
    if (cmd_i.plan) begin
      p_lo0_q <= s_q;
      p_hi0_q <= hi0_d;
      p_lo1_q <= e_q - rev_pos;
      p_hi1_q <= e_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      two_q      <= 1'b0;
      span_sel_q <= 1'b0;
      clr_q      <= '0;
    end else begin
      if (cmd_i.plan) begin
        two_q      <= long_frag;
        span_sel_q <= 1'b0;
      end else if (cmd_i.span_next) begin
        span_sel_q <= 1'b1;
      end
      if (cmd_i.clr_wr) begin
        clr_q <= clr_q + 1'b1;
      end
    end
  end

  fcb_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_abs[QuotW-1:0]),
    .divisor_i  (d_eff),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // a negative low end always lands on bin zero after clamping
  always_ff @(posedge clk_i) begin
    if (cmd_i.lo_take) begin
      lo_bin_q <= cur_lo[PosW-1] ? '0 : quot;
    end
    if (cmd_i.hi_take) begin
      hi_neg_q <= cur_hi[PosW-1] && (quot != '0);
      if (cur_hi[PosW-1]) begin
        hi_bin_q <= '0;
      end else begin
        hi_bin_q <= (quot > MaxBin) ? MaxBin : quot;
      end
    end
    if (cmd_i.range_load) begin
      j_q <= lo_bin_q[AddrW-1:0];
    end else if (cmd_i.j_inc) begin
      j_q <= j_q + 1'b1;
    end
  end

  always_comb begin
    sum     = {1'b0, ram_rdata_i} + {{(CountW+1-WeightW){1'b0}}, w_q};
    wsum    = sum[CountW] ? '1 : sum[CountW-1:0];
    idx_ext = {{(QuotW-BinIdxW){1'b0}}, idx_q};
    if (!rd_ok_q) begin
      value_d = '0;
    end else if (|prod_q[ProdW-1:ValueW+GainFrac]) begin
      value_d = '1;
    end else begin
      value_d = prod_q[ValueW+GainFrac-1:GainFrac];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= {{(ProdW-CountW){1'b0}}, ram_rdata_i} * {{(ProdW-GainW){1'b0}}, gain_q};
    end
    if (cmd_i.out_load) begin
      value_q <= value_d;
    end
  end

  assign ram_we_o    = cmd_i.clr_wr || cmd_i.rmw_wr;
  assign ram_waddr_o = cmd_i.clr_wr ? clr_q : j_q;
  assign ram_wdata_o = cmd_i.clr_wr ? '0 : wsum;
  assign ram_raddr_o = kind_q ? idx_ext[AddrW-1:0] : j_q;
  assign bin_value_o = value_q;

  always_comb begin
    stat_o.in_kind    = kind_i;
    stat_o.in_dup     = is_duplicate_i;
    stat_o.clr_last   = (clr_q == MaxBin[AddrW-1:0]);
    stat_o.div_done   = div_done;
    stat_o.span_empty = hi_neg_q || (lo_bin_q > hi_bin_q);
    stat_o.span_last  = (j_q == hi_bin_q[AddrW-1:0]);
    stat_o.more_spans = two_q && !span_sel_q;
  end

endmodule

/* rtl/fcb_ctrl.sv */
// controller state machine: clearing pass, fragment sequencing, bin readout
module fcb_ctrl import fcb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      item_valid_i,
  output logic      item_ready_o,
  input  logic      result_ready_i,
  output logic      result_valid_o,
  input  fcb_stat_t stat_i,
  output fcb_cmd_t  cmd_o
);

  fcb_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (stat_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (item_valid_i) begin
          if (stat_i.in_kind) begin
            state_d = ST_RD_ADDR;
          end else if (!stat_i.in_dup) begin
            state_d = ST_ORDER;
          end
        end
      end
      ST_ORDER:  state_d = ST_WINDOW;
      ST_WINDOW: state_d = ST_CLAMP;
      ST_CLAMP:  state_d = ST_PLAN;
      ST_PLAN:   state_d = ST_DIV_LO;
      ST_DIV_LO: state_d = ST_WAIT_LO;
      ST_WAIT_LO: begin
        if (stat_i.div_done) state_d = ST_DIV_HI;
      end
      ST_DIV_HI: state_d = ST_WAIT_HI;
      ST_WAIT_HI: begin
        if (stat_i.div_done) state_d = ST_RANGE;
      end
      ST_RANGE: begin
        if (!stat_i.span_empty) begin
          state_d = ST_RMW_RD;
        end else if (stat_i.more_spans) begin
          state_d = ST_DIV_LO;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_RMW_RD: state_d = ST_RMW_WR;
      ST_RMW_WR: begin
        if (!stat_i.span_last) begin
          state_d = ST_RMW_RD;
        end else if (stat_i.more_spans) begin
          state_d = ST_DIV_LO;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_RD_ADDR: state_d = ST_RD_MUL;
      ST_RD_MUL:  state_d = ST_RD_OUT;
      ST_RD_OUT: begin
        if (!out_valid_q || result_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o        = '0;
    item_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: cmd_o.clr_wr = 1'b1;
      ST_IDLE: begin
        item_ready_o = 1'b1;
        cmd_o.latch  = item_valid_i;
      end
      ST_ORDER:  cmd_o.order  = 1'b1;
      ST_WINDOW: cmd_o.window = 1'b1;
      ST_CLAMP:  cmd_o.clamp  = 1'b1;
      ST_PLAN:   cmd_o.plan   = 1'b1;
      ST_DIV_LO: cmd_o.div_start = 1'b1;
      ST_WAIT_LO: cmd_o.lo_take = stat_i.div_done;
      ST_DIV_HI: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_hi    = 1'b1;
      end
      ST_WAIT_HI: begin
        cmd_o.div_hi  = 1'b1;
        cmd_o.hi_take = stat_i.div_done;
      end
      ST_RANGE: begin
        cmd_o.range_load = 1'b1;
        cmd_o.span_next  = stat_i.span_empty && stat_i.more_spans;
      end
      ST_RMW_RD: ;
      ST_RMW_WR: begin
        cmd_o.rmw_wr    = 1'b1;
        cmd_o.j_inc     = !stat_i.span_last;
        cmd_o.span_next = stat_i.span_last && stat_i.more_spans;
      end
      ST_RD_ADDR: ;
      ST_RD_MUL:  cmd_o.mul = 1'b1;
      ST_RD_OUT:  cmd_o.out_load = !out_valid_q || result_ready_i;
      default: ;
    endcase
  end

  // output slot empties when taken, refills on load
  always_comb begin
    out_valid_d = out_valid_q && !result_ready_i;
    if (cmd_o.out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign result_valid_o = out_valid_q;

endmodule

/* rtl/fragment_coverage_binner.sv */
// channel   | dir | payload
// ----------+-----+-------------------------------------------------------------
// item_i    | in  | kind, end_a, end_b, weight, is_duplicate, bin_index
// result_o  | out | bin_value (one per read transaction, none per fragment)
// cfg_*_i   | in  | register index and data, written when cfg_we_i is high
//
// after reset a clearing pass zeroes the bin store, one bin a cycle, all NUM_BINS bins;
// item_i.ready stays low until it ends.
// read transaction steps: accept, ram read, multiply, result register.
// fragment: geometry steps (accept, order, window, clamp, plan), then per span two 32-step serial
// divisions plus a ram read and a ram write per bin; a duplicate is accepted and dropped.
// a result waiting in the output register stalls only the next read transaction.
module fragment_coverage_binner import fcb_pkg::*; #(
  parameter int unsigned NUM_BINS = 262144
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  fcb_item_if.sink            item_i,
  fcb_result_if.source        result_o
);

`include "fragment_coverage_binner_assert.svh"

  localparam int unsigned AddrW = $clog2(NUM_BINS);
  localparam logic [AddrW-1:0] MaxAddr = AddrW'(NUM_BINS - 1);

  fcb_cmd_t          cmd;
  fcb_stat_t         stat;
  logic              ram_we;
  logic [AddrW-1:0]  ram_waddr;
  logic [CountW-1:0] ram_wdata;
  logic [AddrW-1:0]  ram_raddr;
  logic [CountW-1:0] ram_rdata;

  fcb_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (item_i.valid),
    .item_ready_o   (item_i.ready),
    .result_ready_i (result_o.ready),
    .result_valid_o (result_o.valid),
    .stat_i         (stat),
    .cmd_o          (cmd)
  );

  fcb_datapath #(
    .NUM_BINS (NUM_BINS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .kind_i         (item_i.kind),
    .end_a_i        (item_i.end_a),
    .end_b_i        (item_i.end_b),
    .weight_i       (item_i.weight),
    .is_duplicate_i (item_i.is_duplicate),
    .bin_index_i    (item_i.bin_index),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .ram_we_o       (ram_we),
    .ram_waddr_o    (ram_waddr),
    .ram_wdata_o    (ram_wdata),
    .ram_raddr_o    (ram_raddr),
    .ram_rdata_i    (ram_rdata),
    .bin_value_o    (result_o.bin_value)
  );

  fcb_ram #(
    .Width (CountW),
    .Depth (NUM_BINS)
  ) u_bins (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // no transaction taken while the store is being cleared
  `FCB_ASSERT_SAME(a_clear_blocks_input, cmd.clr_wr, !item_i.ready, "input taken during clear")
  // bin writes stay inside the store
  `FCB_ASSERT_SAME(a_write_in_store, ram_we, ram_waddr <= MaxAddr, "bin write outside store")
  // a duplicate fragment leaves the block ready for the next transaction
  `FCB_ASSERT_NEXT(a_dup_skipped, item_i.valid && item_i.ready && !item_i.kind && item_i.is_duplicate, item_i.ready, "duplicate fragment not skipped")
  // a fragment never produces a result
  `FCB_ASSERT_NEXT(a_frag_no_result, item_i.valid && item_i.ready && !item_i.kind && !result_o.valid, !result_o.valid, "result raised by fragment")

endmodule
